// File: hw/rtl/gzip_member_index_parser_defines.svh
// assertion macros shared by the gzip member index parser rtl
`ifndef GZIP_MEMBER_INDEX_PARSER_DEFINES_SVH
`define GZIP_MEMBER_INDEX_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication checked while out of reset
`define GMIP_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication checked while out of reset
`define GMIP_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GMIP_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define GMIP_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg)

`endif

`endif

// File: hw/rtl/gmip_pkg.sv
// shared types and constants of the gzip member index parser
`default_nettype none

package gmip_pkg;

  // width of the running file offset counter
  localparam int OFFSET_BITS = 40;
  // width of the reported payload offset field
  localparam int PAYLOAD_OFFSET_W = 40;

  localparam logic [7:0] GZ_MAGIC0 = 8'h1f;
  localparam logic [7:0] GZ_MAGIC1 = 8'h8b;
  localparam logic [7:0] TAG_I     = 8'h49;
  localparam logic [7:0] TAG_G     = 8'h47;
  localparam int HDR_LEN     = 14;
  localparam int TRAILER_LEN = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_NO_TAG    = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                       status;
    logic [PAYLOAD_OFFSET_W-1:0]   payload_offset;
    logic [31:0]                   payload_length;
    logic [31:0]                   stored_crc;
    logic [31:0]                   raw_size;
    logic [7:0]                    method_code;
    logic [7:0]                    flag_bits;
  } rec_t;

endpackage

`default_nettype wire

// File: hw/rtl/gmip_core.sv
// member parsing state and per-byte update of the gzip member index parser
`default_nettype none
`include "gzip_member_index_parser_defines.svh"

module gmip_core
  import gmip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  output logic            res_valid,
  output rec_t            res
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_EXTRA   = 3'd1,
    PH_NAME    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  // header byte positions
  localparam logic [15:0] HB_MAGIC0 = 16'd0;
  localparam logic [15:0] HB_MAGIC1 = 16'd1;
  localparam logic [15:0] HB_METHOD = 16'd2;
  localparam logic [15:0] HB_FLAGS  = 16'd3;
  localparam logic [15:0] HB_XLEN_L = 16'd10;
  localparam logic [15:0] HB_XLEN_H = 16'd11;
  localparam logic [15:0] HB_TAG_I  = 16'd12;
  localparam logic [15:0] HB_TAG_G  = 16'd13;

  localparam logic [1:0] FAULT_MAGIC = 2'b01;
  localparam logic [1:0] FAULT_TAG   = 2'b10;

  // fixed bytes outside the name and subfield body: header, trailer, less the two tag bytes
  localparam logic [17:0] FIXED_OVH = 18'(HDR_LEN + TRAILER_LEN - 2);

  phase_t                 phase_r, phase_nxt;
  logic [15:0]            cnt_r, cnt_nxt;
  logic [15:0]            ext_len_r, ext_len_nxt;
  logic [31:0]            blk_r, blk_nxt;
  logic [15:0]            name_len_r, name_len_nxt;
  logic [31:0]            left_r, left_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [7:0]             method_r, method_nxt;
  logic [7:0]             flag_r, flag_nxt;
  logic                   halted_r, halted_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [31:0]            hold_r, hold_nxt;
  logic [1:0]             fault_r, fault_nxt;

  logic [OFFSET_BITS-1:0] offset_inc;
  logic [15:0]            cnt_inc;
  logic [15:0]            name_inc;
  logic [17:0]            overhead;
  logic [31:0]            left_new;
  logic [31:0]            left_dec;
  logic [31:0]            lane_byte;
  logic [1:0]             blk_lane;
  logic [31:0]            crc_upd;
  logic [31:0]            size_upd;
  logic [1:0]             fault_tag;
  logic [15:0]            hdr_idx;

  assign offset_inc = offset_r + OFFSET_BITS'(1);
  assign cnt_inc    = cnt_r + 16'd1;
  assign name_inc   = name_len_r + 16'd1;
  assign overhead   = 18'(ext_len_r) + 18'(name_inc) + FIXED_OVH;
  assign left_new   = blk_r - 32'(overhead);
  assign left_dec   = left_r - 32'd1;
  assign lane_byte  = 32'(byte_in);
  // subfield bytes 2..5 land in lanes 0..3
  assign blk_lane   = cnt_r[1:0] - 2'd2;
  assign crc_upd    = (cnt_r < 16'd4) ? (crc_r | (lane_byte << {cnt_r[1:0], 3'b000})) : crc_r;
  assign size_upd   = (cnt_r >= 16'd4 && cnt_r < 16'd8) ?
                      (size_r | (lane_byte << {cnt_r[1:0], 3'b000})) : size_r;
  assign fault_tag  = (byte_in != TAG_G) ? FAULT_TAG : 2'b00;
  // an unused phase code restarts the header from byte 0
  assign hdr_idx    = (phase_r == PH_HEADER) ? cnt_r : HB_MAGIC0;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    ext_len_nxt  = ext_len_r;
    blk_nxt      = blk_r;
    name_len_nxt = name_len_r;
    left_nxt     = left_r;
    offset_nxt   = offset_r;
    crc_nxt      = crc_r;
    size_nxt     = size_r;
    method_nxt   = method_r;
    flag_nxt     = flag_r;
    halted_nxt   = halted_r;
    start_nxt    = start_r;
    hold_nxt     = hold_r;
    fault_nxt    = fault_r;

    res_valid          = 1'b0;
    res.status         = ST_OK;
    res.payload_offset = '0;
    res.payload_length = '0;
    res.stored_crc     = '0;
    res.raw_size       = '0;
    res.method_code    = method_r;
    res.flag_bits      = flag_r;

    if (!halted_r) begin
      offset_nxt = offset_inc;
      case (phase_r)
        PH_EXTRA: begin
          if (cnt_r >= 16'd2 && cnt_r < 16'd6) begin
            blk_nxt = blk_r | (lane_byte << {blk_lane, 3'b000});
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == ext_len_r - 16'd2) begin
            phase_nxt = PH_NAME;
            cnt_nxt   = '0;
          end
        end

        PH_NAME: begin
          if (name_len_r == 16'hffff) begin
            // name too long to count
            halted_nxt = 1'b1;
            res_valid  = 1'b1;
            res.status = ST_BAD_LEN;
          end else begin
            name_len_nxt = name_inc;
            if (byte_in == 8'd0) begin
              if (blk_r < 32'(overhead)) begin
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_BAD_LEN;
              end else begin
                left_nxt  = left_new;
                hold_nxt  = left_new;
                start_nxt = offset_inc;
                phase_nxt = (left_new != 32'd0) ? PH_PAYLOAD : PH_TRAILER;
                cnt_nxt   = '0;
              end
            end
          end
        end

        PH_PAYLOAD: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_TRAILER;
            cnt_nxt   = '0;
          end
        end

        PH_TRAILER: begin
          crc_nxt  = crc_upd;
          size_nxt = size_upd;
          if (cnt_r >= 16'(TRAILER_LEN - 1)) begin
            res_valid          = 1'b1;
            res.status         = ST_OK;
            res.payload_offset = PAYLOAD_OFFSET_W'(start_r);
            res.payload_length = hold_r;
            res.stored_crc     = crc_upd;
            res.raw_size       = size_upd;
            phase_nxt          = PH_HEADER;
            cnt_nxt            = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end

        default: begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = hdr_idx + 16'd1;
          case (hdr_idx)
            HB_MAGIC0: begin
              ext_len_nxt  = '0;
              blk_nxt      = '0;
              name_len_nxt = '0;
              crc_nxt      = '0;
              size_nxt     = '0;
              method_nxt   = '0;
              flag_nxt     = '0;
              fault_nxt    = (byte_in != GZ_MAGIC0) ? FAULT_MAGIC : 2'b00;
            end
            HB_MAGIC1: begin
              if (byte_in != GZ_MAGIC1) begin
                fault_nxt = fault_r | FAULT_MAGIC;
              end
            end
            HB_METHOD: method_nxt = byte_in;
            HB_FLAGS:  flag_nxt   = byte_in;
            HB_XLEN_L: ext_len_nxt = {8'd0, byte_in};
            HB_XLEN_H: ext_len_nxt = {byte_in, ext_len_r[7:0]};
            HB_TAG_I: begin
              if (byte_in != TAG_I) begin
                fault_nxt = fault_r | FAULT_TAG;
              end
            end
            HB_TAG_G: begin
              fault_nxt = fault_r | fault_tag;
              cnt_nxt   = cnt_r;
              // checks in priority order: magic, tag, extra length
              if ((fault_r & FAULT_MAGIC) != 2'b00) begin
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_BAD_MAGIC;
              end else if (((fault_r | fault_tag) & FAULT_TAG) != 2'b00) begin
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_NO_TAG;
              end else if (ext_len_r < 16'd2) begin
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res.status = ST_BAD_LEN;
              end else begin
                cnt_nxt   = '0;
                phase_nxt = (ext_len_r == 16'd2) ? PH_NAME : PH_EXTRA;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      halted_r <= 1'b0;
      offset_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      offset_r <= offset_nxt;
    end
    if (step) begin
      ext_len_r  <= ext_len_nxt;
      blk_r      <= blk_nxt;
      name_len_r <= name_len_nxt;
      left_r     <= left_nxt;
      crc_r      <= crc_nxt;
      size_r     <= size_nxt;
      method_r   <= method_nxt;
      flag_r     <= flag_nxt;
      start_r    <= start_nxt;
      hold_r     <= hold_nxt;
      fault_r    <= fault_nxt;
    end
  end

  `GMIP_ASSERT(a_halted_silent, clk, rst_n, halted_r |-> !res_valid, "record while halted")
  `GMIP_ASSERT(a_hdr_cnt_range, clk, rst_n, (phase_r == PH_HEADER) |-> (cnt_r <= HB_TAG_G), "header count past tag")
  `GMIP_ASSERT(a_ok_from_trailer, clk, rst_n, (res_valid && res.status == ST_OK) |-> (phase_r == PH_TRAILER), "ok record outside trailer")
  `GMIP_ASSERT_NEXT(a_after_record, clk, rst_n, step && res_valid, halted_r || phase_r == PH_HEADER, "parser did not restart or halt")

endmodule

`default_nettype wire

// File: hw/rtl/gzip_member_index_parser.sv
// Multi-member gzip index parser. Takes the file one byte per transfer and emits one
// record per member after its last trailer byte, or one error record (bad magic, missing
// IG tag, inconsistent length) after which it ignores input until reset. Sustained rate
// is one byte per cycle while no record is held back by a full result slot: each byte
// goes through an input register, one pass of the per-byte update, and a result register.
// A byte that causes no record keeps flowing while a record waits on out_ready; only a
// byte that would cause a second record waits for the result slot.
`default_nettype none
`include "gzip_member_index_parser_defines.svh"

module gzip_member_index_parser
  import gmip_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_byte_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [PAYLOAD_OFFSET_W-1:0]      out_payload_offset,
  output logic [31:0]                      out_payload_length,
  output logic [31:0]                      out_stored_crc,
  output logic [31:0]                      out_raw_size,
  output logic [7:0]                       out_method_code,
  output logic [7:0]                       out_flag_bits
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  rec_t       out_rec_r;

  logic       res_valid;
  rec_t       res;
  logic       step;

  // a byte moves on unless it makes a record and the result slot stays full
  assign step     = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  gmip_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_in;
    end
    if (step && res_valid) begin
      out_rec_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_rec_r.status;
  assign out_payload_offset = out_rec_r.payload_offset;
  assign out_payload_length = out_rec_r.payload_length;
  assign out_stored_crc     = out_rec_r.stored_crc;
  assign out_raw_size       = out_rec_r.raw_size;
  assign out_method_code    = out_rec_r.method_code;
  assign out_flag_bits      = out_rec_r.flag_bits;

  `GMIP_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !step, s1_valid_r && $stable(s1_byte_r), "input stage lost a byte")
  `GMIP_ASSERT_NEXT(a_rec_lands, clk, rst_n, step && res_valid, out_valid_r, "record not registered")
  `GMIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_rec_r), "record not held")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the gzip member index parser: member streams, record checks, fault handling
`default_nettype none

module tb_top;
  import gmip_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int ITEM_TARGET  = 1300;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [2:0] {P_HDR, P_XTRA, P_NAME, P_PAY, P_TRL} parse_phase_t;
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;
  typedef enum int {
    FC_TRUNCATED, FC_MAGIC, FC_TAG, FC_SHORT_XLEN, FC_UNDERFLOW
  } fault_case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte_in = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [PAYLOAD_OFFSET_W-1:0] out_payload_offset;
  logic [31:0] out_payload_length;
  logic [31:0] out_stored_crc;
  logic [31:0] out_raw_size;
  logic [7:0] out_method_code;
  logic [7:0] out_flag_bits;

  gzip_member_index_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_stored_crc     (out_stored_crc),
    .out_raw_size       (out_raw_size),
    .out_method_code    (out_method_code),
    .out_flag_bits      (out_flag_bits)
  );

  always #6 clk = ~clk;

  // member index state, mirrors the parser
  parse_phase_t           gz_phase = P_HDR;
  logic [15:0]            gz_count = '0;
  logic [15:0]            gz_xlen = '0;
  logic [31:0]            gz_bsize = '0;
  logic [15:0]            gz_nlen = '0;
  logic [31:0]            gz_left = '0;
  logic [31:0]            gz_plen = '0;
  logic [OFFSET_BITS-1:0] gz_off = '0;
  logic [OFFSET_BITS-1:0] gz_start = '0;
  logic [31:0]            gz_crc = '0;
  logic [31:0]            gz_size = '0;
  logic [7:0]             gz_method = '0;
  logic [7:0]             gz_flags = '0;
  logic                   gz_halted = 1'b0;
  logic                   gz_bad_magic = 1'b0;
  logic                   gz_bad_tag = 1'b0;

  rec_t       member_rec_q[$];
  logic [7:0] mem_q[$];

  int n_fail = 0;
  int n_records = 0;
  int bytes_sent = 0;
  int members_sent = 0;
  int n_ignored = 0;
  int n_in_stalls = 0;
  int cycle_cnt = 0;

  bit       gaps_on = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_phase = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  fault_case_t closing_case = FC_TRUNCATED;

  function automatic rec_t fault_record(input status_t st);
    rec_t r;
    r = '0;
    r.status = st;
    r.method_code = gz_method;
    r.flag_bits = gz_flags;
    gz_halted = 1'b1;
    return r;
  endfunction

  // advance the index state by one file byte; returns 1 when a record is due
  function automatic bit parse_byte(input logic [7:0] b, output rec_t rec);
    logic [15:0] idx;
    logic [32:0] ovh;
    rec = '0;
    if (gz_halted) return 1'b0;
    gz_off = gz_off + OFFSET_BITS'(1);
    idx = gz_count;
    case (gz_phase)
      P_XTRA: begin
        // subfield bytes 2..5 carry the total member size
        if (idx >= 2 && idx < 6) gz_bsize = gz_bsize | (32'(b) << (8 * (idx - 2)));
        gz_count = idx + 16'd1;
        if (gz_count == gz_xlen - 16'd2) begin
          gz_phase = P_NAME;
          gz_count = '0;
        end
        return 1'b0;
      end
      P_NAME: begin
        if (gz_nlen == 16'hffff) begin
          rec = fault_record(ST_BAD_LEN);
          return 1'b1;
        end
        gz_nlen = gz_nlen + 16'd1;
        if (b != 8'h00) return 1'b0;
        ovh = 33'(HDR_LEN + TRAILER_LEN) + 33'(gz_xlen - 16'd2) + 33'(gz_nlen);
        if (33'(gz_bsize) < ovh) begin
          rec = fault_record(ST_BAD_LEN);
          return 1'b1;
        end
        gz_left = gz_bsize - ovh[31:0];
        gz_plen = gz_left;
        gz_start = gz_off;
        gz_phase = (gz_left != 0) ? P_PAY : P_TRL;
        gz_count = '0;
        return 1'b0;
      end
      P_PAY: begin
        gz_left = gz_left - 32'd1;
        if (gz_left == 0) begin
          gz_phase = P_TRL;
          gz_count = '0;
        end
        return 1'b0;
      end
      P_TRL: begin
        if (idx < 4) gz_crc = gz_crc | (32'(b) << (8 * idx));
        else if (idx < 8) gz_size = gz_size | (32'(b) << (8 * (idx - 4)));
        if (idx >= 7) begin
          rec.status = ST_OK;
          rec.payload_offset = PAYLOAD_OFFSET_W'(gz_start);
          rec.payload_length = gz_plen;
          rec.stored_crc = gz_crc;
          rec.raw_size = gz_size;
          rec.method_code = gz_method;
          rec.flag_bits = gz_flags;
          gz_phase = P_HDR;
          gz_count = '0;
          return 1'b1;
        end
        gz_count = idx + 16'd1;
        return 1'b0;
      end
      default: begin
        if (gz_phase != P_HDR) begin
          gz_phase = P_HDR;
          idx = '0;
        end
        case (idx)
          16'd0: begin
            gz_xlen = '0;
            gz_bsize = '0;
            gz_nlen = '0;
            gz_crc = '0;
            gz_size = '0;
            gz_method = '0;
            gz_flags = '0;
            gz_bad_tag = 1'b0;
            gz_bad_magic = (b != GZ_MAGIC0);
          end
          16'd1: if (b != GZ_MAGIC1) gz_bad_magic = 1'b1;
          16'd2: gz_method = b;
          16'd3: gz_flags = b;
          16'd10: gz_xlen = {8'h00, b};
          16'd11: gz_xlen[15:8] = b;
          16'd12: if (b != TAG_I) gz_bad_tag = 1'b1;
          16'd13: begin
            // all header checks land here, magic first
            if (b != TAG_G) gz_bad_tag = 1'b1;
            if (gz_bad_magic) begin
              rec = fault_record(ST_BAD_MAGIC);
              return 1'b1;
            end
            if (gz_bad_tag) begin
              rec = fault_record(ST_NO_TAG);
              return 1'b1;
            end
            if (gz_xlen < 16'd2) begin
              rec = fault_record(ST_BAD_LEN);
              return 1'b1;
            end
            gz_count = '0;
            gz_phase = (gz_xlen == 16'd2) ? P_NAME : P_XTRA;
            return 1'b0;
          end
          default: ;
        endcase
        gz_count = idx + 16'd1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic cmp_field(input string fname, input logic [63:0] want_v, got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want_v, got_v);
      n_fail++;
    end
  endtask

  // record check first, then byte transfer into the index state
  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_valid && out_ready) begin
      n_records++;
      if (member_rec_q.size() == 0) begin
        $display("%0t: unexpected record, expected none, got status %0d offset 0x%0h",
                 $time, out_status, out_payload_offset);
        n_fail++;
      end else begin
        want = member_rec_q.pop_front();
        cmp_field("status", 64'(want.status), 64'(out_status));
        cmp_field("payload_offset", 64'(want.payload_offset), 64'(out_payload_offset));
        cmp_field("payload_length", 64'(want.payload_length), 64'(out_payload_length));
        cmp_field("stored_crc", 64'(want.stored_crc), 64'(out_stored_crc));
        cmp_field("raw_size", 64'(want.raw_size), 64'(out_raw_size));
        cmp_field("method_code", 64'(want.method_code), 64'(out_method_code));
        cmp_field("flag_bits", 64'(want.flag_bits), 64'(out_flag_bits));
      end
    end
    if (rst_n && in_valid && !in_ready) n_in_stalls++;
    if (rst_n && in_valid && in_ready) begin
      if (gz_halted) n_ignored++;
      if (parse_byte(in_byte_in, want)) member_rec_q.insert(member_rec_q.size(), want);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $time, member_rec_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // result side stalls; a requested hold-off overrides the current pattern
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready <= ((rx_phase % 7) < 4);
        RX_SLOW:    out_ready <= ($urandom_range(0, 9) == 0);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left != 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic send_member();
    for (int i = 0; i < mem_q.size(); i++) send_byte(mem_q[i]);
    members_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic trim_to(input int n);
    while (mem_q.size() > n) mem_q.delete(mem_q.size() - 1);
  endtask

  task automatic add_byte(input logic [7:0] b);
    mem_q.insert(mem_q.size(), b);
  endtask

  // one member; name_len counts the terminator, bs_delta skews the stored size
  task automatic build_member(input int xlen, input int name_len, input int pay_len,
                              input int bs_delta);
    logic [31:0] bsize_v;
    bsize_v = 32'(HDR_LEN + TRAILER_LEN + (xlen - 2) + name_len + pay_len + bs_delta);
    mem_q.delete();
    add_byte(GZ_MAGIC0);
    add_byte(GZ_MAGIC1);
    repeat (8) add_byte(8'($urandom));
    add_byte(xlen[7:0]);
    add_byte(xlen[15:8]);
    add_byte(TAG_I);
    add_byte(TAG_G);
    for (int i = 0; i < xlen - 2; i++)
      add_byte((i >= 2 && i < 6) ? bsize_v[8*(i-2) +: 8] : 8'($urandom));
    for (int i = 1; i < name_len; i++) add_byte(8'($urandom_range(1, 255)));
    add_byte(8'h00);
    repeat (pay_len) add_byte(8'($urandom));
    repeat (TRAILER_LEN) add_byte(8'($urandom));
  endtask

  task automatic pin_fields(input logic [7:0] v);
    mem_q[2] = v;
    mem_q[3] = v;
    for (int i = mem_q.size() - TRAILER_LEN; i < mem_q.size(); i++) mem_q[i] = v;
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    // shortest well-formed member: one-byte size, bare terminator, no payload
    build_member(5, 1, 0, 0);
    pin_fields(8'h00);
    send_member();
    build_member(8, 3, 1, 0);
    pin_fields(8'hff);
    send_member();
    // two- and three-byte size fields
    build_member(6, 1, 2, 0);
    send_member();
    build_member(7, 2, 0, 0);
    send_member();
    // extra field longer than 255 bytes
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    build_member(300, 2, 3, 0);
    send_member();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_req = 1'b1;
    repeat (10) begin
      build_member($urandom_range(5, 8), $urandom_range(1, 3), $urandom_range(0, 4), 0);
      send_member();
    end
  endtask

  task automatic test_random_members();
    int xlen;
    int nlen;
    int plen;
    while (bytes_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      xlen = ($urandom_range(0, 24) == 0) ? $urandom_range(200, 300) : $urandom_range(5, 12);
      nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16);
      build_member(xlen, nlen, plen, 0);
      send_member();
    end
  endtask

  // the parser halts on any fault, so only one fault case fits in a run
  task automatic test_terminal_fault();
    int nlen;
    int xlen;
    int skew;
    nlen = $urandom_range(1, 6);
    xlen = 8;
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    closing_case = fault_case_t'($urandom_range(0, 4));
    build_member(xlen, nlen, $urandom_range(0, 10), 0);
    case (closing_case)
      FC_TRUNCATED: trim_to($urandom_range(1, mem_q.size() - 1));
      FC_MAGIC: begin
        if ($urandom_range(0, 1)) mem_q[0] = mem_q[0] ^ 8'($urandom_range(1, 255));
        else mem_q[1] = mem_q[1] ^ 8'($urandom_range(1, 255));
        // lower-priority faults in the same header must not win
        if ($urandom_range(0, 1)) mem_q[12] = mem_q[12] ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) mem_q[10] = 8'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) mem_q[11] = 8'h00;
        trim_to(HDR_LEN);
      end
      FC_TAG: begin
        if ($urandom_range(0, 1)) mem_q[12] = mem_q[12] ^ 8'($urandom_range(1, 255));
        else mem_q[13] = mem_q[13] ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) begin
          mem_q[10] = 8'($urandom_range(0, 1));
          mem_q[11] = 8'h00;
        end
        trim_to(HDR_LEN);
      end
      FC_SHORT_XLEN: begin
        mem_q[10] = 8'($urandom_range(0, 1));
        mem_q[11] = 8'h00;
        trim_to(HDR_LEN);
      end
      FC_UNDERFLOW: begin
        if ($urandom_range(0, 1)) begin
          // no size bytes in the subfield, so the size reads as zero
          xlen = $urandom_range(2, 4);
          build_member(xlen, nlen, 0, 0);
        end else begin
          skew = $urandom_range(1, HDR_LEN + TRAILER_LEN + 6 + nlen);
          build_member(xlen, nlen, 0, -skew);
        end
        trim_to(HDR_LEN + xlen - 2 + nlen);
      end
      default: ;
    endcase
    // bytes after a fault must be swallowed without a record
    if (closing_case != FC_TRUNCATED) repeat (24) add_byte(8'($urandom));
    send_member();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_members();
    test_terminal_fault();
    stop_input();
    rx_mode = RX_ALWAYS;
    while (member_rec_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes in %0d members, %0d records checked, %0d input stall cycles",
             bytes_sent, members_sent, n_records, n_in_stalls);
    $display("closing case %s, %0d bytes dropped after the fault",
             closing_case.name(), n_ignored);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
